### design/ptu_pkg.sv
// Package for the pheromone trail update block: operation codes,
// default sizes and fixed-point constants.
// No dependencies.
package ptu_pkg;

    localparam int VERTICES_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int KEEP_W       = 16;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 16'd58982;
    localparam logic [DATA_W-1:0] SAT_VALUE  = 32'hFFFF_FFFF;

    // Divide 2^32 by the cost: one quotient bit for each dividend bit 32..0
    localparam int               DIV_STEPS = 33;
    localparam logic [5:0]       DIV_TOP   = 6'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_EVAP    = 3'd1,
        OP_BEGIN   = 3'd2,
        OP_DEPOSIT = 3'd3,
        OP_READ    = 3'd4
    } t_op;

endpackage

### design/ptu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ptu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/pheromone_trail_update_top.sv
// Pheromone trail update block: a VERTICES x VERTICES table of Q8.24 levels
// in one RAM, with write, evaporate, begin (quality = 2^32 / cost), deposit
// and read operations. Depends on ptu_pkg and ptu_ram.
//
// One word is taken at a time. Write, unknown codes, out-of-range edges and
// begin with cost zero or one finish in the idle state; read and deposit
// read the RAM, then give the result or write back in their own state;
// begin with a larger cost runs the bit-serial divider, one quotient bit per
// cycle; evaporate sweeps the RAM through one read port and one write port,
// then writes back the last entry. After reset a clearing pass writes zero
// to every entry, during which no word is taken; keep-factor writes are
// taken at any time. A finished result waits in the output register while
// the next word is taken.
module pheromone_trail_update_top
    import ptu_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [KEEP_W-1:0] i_cfg_keep_factor,
    // input words
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_operation,
    input  logic [5:0]        i_from_vertex,
    input  logic [5:0]        i_to_vertex,
    input  logic [DATA_W-1:0] i_payload,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_entry_value,
    output logic              o_zero_cost
);

    localparam int            DEPTH = VERTICES * VERTICES;
    localparam int            AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_EVAP,
        S_EVDR,
        S_DIV,
        S_DEP,
        S_RD,
        S_WAIT
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_wr_addr;
    logic              r_wr_vld;
    logic [AW-1:0]     r_slot;
    logic [KEEP_W-1:0] r_keep;
    logic [DATA_W-1:0] r_quality;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [5:0]        r_dcnt;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_flag;
    logic [DATA_W-1:0] r_pend_value;
    logic              r_pend_flag;

    logic              in_fire;
    logic              in_range;
    logic [AW-1:0]     slot;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [47:0]       prod;
    logic [DATA_W:0]   dep_sum;
    logic [DATA_W:0]   dstep;
    logic              dge;
    logic              fin;
    logic [DATA_W-1:0] fin_value;
    logic              fin_flag;

    ptu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_zero_cost   = r_out_flag;

    assign in_fire  = i_in_valid && o_in_ready;
    assign in_range = (int'(i_from_vertex) < VERTICES) && (int'(i_to_vertex) < VERTICES);
    assign slot     = AW'(AW'(i_from_vertex) * AW'(VERTICES) + AW'(i_to_vertex));
    assign out_free = !r_out_valid || i_out_ready;

    assign prod    = 48'(ram_rdata) * 48'(r_keep);
    assign dep_sum = (DATA_W+1)'(ram_rdata) + (DATA_W+1)'(r_quality);
    // only the first dividend bit (bit 32 of 2^32) is one
    assign dstep   = {r_rem, (r_dcnt == DIV_TOP)};
    assign dge     = (dstep >= (DATA_W+1)'(r_div));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = prod[47:16];
        ram_raddr = slot;
        fin       = 1'b0;
        fin_value = '0;
        fin_flag  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_operation)
                        OP_WRITE: begin
                            ram_we    = in_range;
                            ram_waddr = slot;
                            ram_wdata = i_payload;
                            fin       = 1'b1;
                        end
                        OP_EVAP: begin
                            fin = 1'b0;
                        end
                        OP_BEGIN: begin
                            fin      = (i_payload <= DATA_W'(1));
                            fin_flag = (i_payload == '0);
                        end
                        OP_DEPOSIT, OP_READ: begin
                            fin = !in_range;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_EVAP: begin
                ram_raddr = r_idx;
                ram_we    = r_wr_vld;
            end
            S_EVDR: begin
                ram_raddr = r_idx;
                ram_we    = 1'b1;
                fin       = 1'b1;
            end
            S_DIV: begin
                fin = (r_dcnt == '0);
            end
            S_DEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = dep_sum[DATA_W] ? SAT_VALUE : dep_sum[DATA_W-1:0];
                fin       = 1'b1;
            end
            S_RD: begin
                fin       = 1'b1;
                fin_value = ram_rdata;
            end
            S_WAIT: begin
                fin = 1'b0;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_wr_vld    <= 1'b0;
            r_keep      <= KEEP_RESET;
            r_quality   <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_keep <= i_cfg_keep_factor;
            end

            unique case (r_state)
                S_CLR: begin
                    r_idx <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_slot <= slot;
                        r_div  <= i_payload;
                        unique case (i_operation)
                            OP_EVAP: begin
                                r_idx    <= '0;
                                r_wr_vld <= 1'b0;
                                r_state  <= S_EVAP;
                            end
                            OP_BEGIN: begin
                                if (i_payload <= DATA_W'(1)) begin
                                    r_quality <= SAT_VALUE;
                                end else begin
                                    r_rem   <= '0;
                                    r_dcnt  <= DIV_TOP;
                                    r_state <= S_DIV;
                                end
                            end
                            OP_DEPOSIT: begin
                                if (in_range) begin
                                    r_state <= S_DEP;
                                end
                            end
                            OP_READ: begin
                                if (in_range) begin
                                    r_state <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EVAP: begin
                    // read one entry ahead, write back the one read last cycle
                    r_wr_vld  <= 1'b1;
                    r_wr_addr <= r_idx;
                    r_idx     <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_state <= S_EVDR;
                    end
                end
                S_DIV: begin
                    r_rem  <= dge ? DATA_W'(dstep - (DATA_W+1)'(r_div)) : dstep[DATA_W-1:0];
                    r_quo  <= {r_quo[DATA_W-2:0], dge};
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == '0) begin
                        r_quality <= {r_quo[DATA_W-2:0], dge};
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: ;
            endcase

            // hand the result to the output register, or park it
            if (fin) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                    r_out_value <= fin_value;
                    r_out_flag  <= fin_flag;
                    r_state     <= S_IDLE;
                end else begin
                    r_pend_value <= fin_value;
                    r_pend_flag  <= fin_flag;
                    r_state      <= S_WAIT;
                end
            end else if (r_state == S_WAIT && out_free) begin
                r_out_valid <= 1'b1;
                r_out_value <= r_pend_value;
                r_out_flag  <= r_pend_flag;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_evap_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAP && r_wr_vld) |-> (ram_raddr != ram_waddr))
        else $error("evaporate sweep reads and writes the same entry");

    a_deposit_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_operation == OP_DEPOSIT && in_range) |=> (r_state == S_DEP))
        else $error("deposit did not go to write-back");

    a_flag_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_cost) |-> (o_entry_value == '0))
        else $error("zero cost flag with nonzero entry value");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt <= DIV_TOP))
        else $error("divider step count out of range");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!o_in_ready && ram_we))
        else $error("word taken or write missed during clearing pass");
`endif

endmodule
